>>> src/pressure_temp_compensation_macros.svh
// assertion macros used by the pressure/temperature compensation checker
`ifndef PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PTC_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define PTC_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

>>> src/ptc_pkg.sv
// shared types and constants for the pressure/temperature compensation block
package ptc_pkg;

	localparam int RAW_W     = 24;
	localparam int CAL_W     = 16;
	localparam int RES_W     = 32;
	localparam int CFG_IDX_W = 3;

	// calibration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS_BASE   = 3'd0,
		REG_OFF_BASE    = 3'd1,
		REG_SENS_TEMPCO = 3'd2,
		REG_OFF_TEMPCO  = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_COEFF  = 3'd5
	} ptc_reg_t;

	// factory calibration words c1..c6
	typedef struct packed {
		logic [CAL_W-1:0] sens_base;
		logic [CAL_W-1:0] off_base;
		logic [CAL_W-1:0] sens_tempco;
		logic [CAL_W-1:0] off_tempco;
		logic [CAL_W-1:0] ref_temp;
		logic [CAL_W-1:0] temp_coeff;
	} ptc_cfg_t;

	localparam logic signed [19:0] T_REF   = 20'sd2000;
	localparam logic signed [19:0] T_VLOW  = -20'sd1500;
	localparam logic [RES_W-1:0]   SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [RES_W-1:0]   SAT_MIN = 32'h8000_0000;

endpackage

>>> src/ptc_cfg.sv
// calibration register file with its write channel
module ptc_cfg import ptc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_data,
	output ptc_cfg_t             cal
);

	ptc_cfg_t cal_q;

	assign cfg_ready = 1'b1;
	assign cal       = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			case (ptc_reg_t'(cfg_index))
				REG_SENS_BASE:   cal_q.sens_base   <= cfg_data;
				REG_OFF_BASE:    cal_q.off_base    <= cfg_data;
				REG_SENS_TEMPCO: cal_q.sens_tempco <= cfg_data;
				REG_OFF_TEMPCO:  cal_q.off_tempco  <= cfg_data;
				REG_REF_TEMP:    cal_q.ref_temp    <= cfg_data;
				REG_TEMP_COEFF:  cal_q.temp_coeff  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> src/pressure_temp_compensation.sv
// second-order temperature compensation for a 24-bit pressure sensor, ten-stage pipeline
// each input transfer is registered through stages s1 to s10 before its result reaches the output
// throughput: one pair per cycle; the whole pipe advances while the last stage is empty or taken
// s_axis_tready falls only while a result waits in the output stage and m_axis_tready is low
// reset clears all stage valid bits and the calibration words to zero
module pressure_temp_compensation import ptc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata,   // temperature[31:0], pressure[63:32]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CAL_W-1:0]     cfg_data
);

	ptc_cfg_t cal;

	ptc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	// global advance: the pipe moves when the output stage is free or being taken
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	assign adv           = !vld_s10 || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	// stage 1: temperature difference dT = d2 - c5*256
	logic [RAW_W-1:0]   d1_s1;
	logic signed [24:0] dt_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1 <= s_axis_tdata[23:0];
			dt_s1 <= $signed({1'b0, s_axis_tdata[47:24]})
				- $signed({1'b0, cal.ref_temp, 8'h00});
		end
	end

	// stage 2: the four products of dT
	logic signed [41:0] psens_c, poff_c, pt_c;
	logic signed [49:0] dtsq_c;
	logic signed [41:0] psens_s2, poff_s2, pt_s2;
	logic [47:0]        dtsq_s2;
	logic [RAW_W-1:0]   d1_s2;

	always_comb begin
		psens_c = dt_s1 * $signed({1'b0, cal.sens_tempco});
		poff_c  = dt_s1 * $signed({1'b0, cal.off_tempco});
		pt_c    = dt_s1 * $signed({1'b0, cal.temp_coeff});
		dtsq_c  = dt_s1 * dt_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			psens_s2 <= psens_c;
			poff_s2  <= poff_c;
			pt_s2    <= pt_c;
			dtsq_s2  <= dtsq_c[47:0];
			d1_s2    <= d1_s1;
		end
	end

	// stage 3: SENS, OFF, first-order T and both Ti candidates
	// signed shifts round toward zero by biasing negative values first
	logic signed [41:0] psens_d, poff_d, pt_d;
	logic [49:0]        dtsq3_c;
	logic signed [35:0] sens_c;
	logic signed [36:0] off_c;
	logic signed [19:0] t_c;
	logic signed [35:0] sens_s3;
	logic signed [36:0] off_s3;
	logic signed [19:0] t_s3;
	logic [16:0]        ti_lo_s3;
	logic [11:0]        ti_hi_s3;
	logic [RAW_W-1:0]   d1_s3;

	always_comb begin
		psens_d = (psens_s2 + (psens_s2[41] ? 42'sd255 : 42'sd0)) >>> 8;
		poff_d  = (poff_s2 + (poff_s2[41] ? 42'sd127 : 42'sd0)) >>> 7;
		pt_d    = (pt_s2 + (pt_s2[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
		sens_c  = $signed({5'd0, cal.sens_base, 15'd0}) + $signed(psens_d[35:0]);
		off_c   = $signed({5'd0, cal.off_base, 16'd0}) + $signed(poff_d[36:0]);
		t_c     = T_REF + $signed(pt_d[19:0]);
		dtsq3_c = {1'b0, dtsq_s2, 1'b0} + {2'b00, dtsq_s2};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sens_s3  <= sens_c;
			off_s3   <= off_c;
			t_s3     <= t_c;
			ti_lo_s3 <= dtsq3_c[49:33];
			ti_hi_s3 <= dtsq_s2[47:36];
			d1_s3    <= d1_s2;
		end
	end

	// stage 4: branch select, squared deviations and final temperature
	logic signed [19:0] dev_c, lo_c;
	logic signed [39:0] devsq_c, losq_c;
	logic               low_c;
	logic signed [19:0] temp_c;
	logic [35:0]        devsq_s4, losq_s4;
	logic               low_s4, vlow_s4;
	logic signed [19:0] temp_s4;
	logic signed [35:0] sens_s4;
	logic signed [36:0] off_s4;
	logic [RAW_W-1:0]   d1_s4;

	always_comb begin
		dev_c   = t_s3 - T_REF;
		lo_c    = t_s3 - T_VLOW;
		devsq_c = dev_c * dev_c;
		losq_c  = lo_c * lo_c;
		low_c   = t_s3 < T_REF;
		temp_c  = low_c ? (t_s3 - $signed({3'd0, ti_lo_s3}))
				: (t_s3 - $signed({8'd0, ti_hi_s3}));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			devsq_s4 <= devsq_c[35:0];
			losq_s4  <= losq_c[35:0];
			low_s4   <= low_c;
			vlow_s4  <= t_s3 < T_VLOW;
			temp_s4  <= temp_c;
			sens_s4  <= sens_s3;
			off_s4   <= off_s3;
			d1_s4    <= d1_s3;
		end
	end

	// stage 5: second-order offset and sensitivity terms
	logic [37:0]        dev3_c;
	logic [38:0]        dev5_c, lo7_c;
	logic [37:0]        lo4_c;
	logic [39:0]        offi_c, sensi_c;
	logic [39:0]        offi_s5, sensi_s5;
	logic signed [19:0] temp_s5;
	logic signed [35:0] sens_s5;
	logic signed [36:0] off_s5;
	logic [RAW_W-1:0]   d1_s5;

	always_comb begin
		dev3_c = {1'b0, devsq_s4, 1'b0} + {2'b00, devsq_s4};
		dev5_c = {1'b0, devsq_s4, 2'b00} + {3'b000, devsq_s4};
		lo7_c  = {losq_s4, 3'b000} - {3'b000, losq_s4};
		lo4_c  = {losq_s4, 2'b00};
		if (low_s4) begin
			offi_c  = {3'd0, dev3_c[37:1]} + (vlow_s4 ? {1'b0, lo7_c} : 40'd0);
			sensi_c = {4'd0, dev5_c[38:3]} + (vlow_s4 ? {2'b00, lo4_c} : 40'd0);
		end else begin
			offi_c  = {8'd0, devsq_s4[35:4]};
			sensi_c = 40'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			offi_s5  <= offi_c;
			sensi_s5 <= sensi_c;
			temp_s5  <= temp_s4;
			sens_s5  <= sens_s4;
			off_s5   <= off_s4;
			d1_s5    <= d1_s4;
		end
	end

	// stage 6: corrected OFF2 and SENS2
	logic signed [41:0] sens2_s6, off2_s6;
	logic signed [19:0] temp_s6;
	logic [RAW_W-1:0]   d1_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			sens2_s6 <= $signed({{6{sens_s5[35]}}, sens_s5}) - $signed({2'b00, sensi_s5});
			off2_s6  <= $signed({{5{off_s5[36]}}, off_s5}) - $signed({2'b00, offi_s5});
			temp_s6  <= temp_s5;
			d1_s6    <= d1_s5;
		end
	end

	// stage 7: d1 * SENS2 as two partial products over the split SENS2 word
	logic [44:0]        pp_lo_s7;
	logic signed [45:0] pp_hi_s7;
	logic signed [41:0] off2_s7;
	logic signed [19:0] temp_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			pp_lo_s7 <= d1_s6 * sens2_s6[20:0];
			pp_hi_s7 <= $signed({1'b0, d1_s6}) * $signed(sens2_s6[41:21]);
			off2_s7  <= off2_s6;
			temp_s7  <= temp_s6;
		end
	end

	// stage 8: recombine the partial products
	logic signed [66:0] prod_s8;
	logic signed [41:0] off2_s8;
	logic signed [19:0] temp_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s8 <= $signed({pp_hi_s7, 21'd0}) + $signed({22'd0, pp_lo_s7});
			off2_s8 <= off2_s7;
			temp_s8 <= temp_s7;
		end
	end

	// stage 9: scale by 2^-21 toward zero and remove the offset
	logic signed [66:0] prod_d;
	logic signed [46:0] diff_s9;
	logic signed [19:0] temp_s9;

	always_comb begin
		prod_d = (prod_s8 + (prod_s8[66] ? 67'sd2097151 : 67'sd0)) >>> 21;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			diff_s9 <= $signed(prod_d[46:0]) - $signed({{5{off2_s8[41]}}, off2_s8});
			temp_s9 <= temp_s8;
		end
	end

	// stage 10: scale by 2^-13 toward zero and saturate to 32 bits
	logic signed [46:0] press_d;
	logic               over_pos, over_neg;
	logic [RES_W-1:0]   press_c;
	logic [RES_W-1:0]   press_s10;
	logic signed [19:0] temp_s10;

	always_comb begin
		press_d  = (diff_s9 + (diff_s9[46] ? 47'sd8191 : 47'sd0)) >>> 13;
		over_pos = !press_d[46] && (|press_d[45:31]);
		over_neg = press_d[46] && !(&press_d[45:31]);
		if (over_pos) begin
			press_c = SAT_MAX;
		end else if (over_neg) begin
			press_c = SAT_MIN;
		end else begin
			press_c = press_d[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			press_s10 <= press_c;
			temp_s10  <= temp_s9;
		end
	end

	// temperature always fits well inside 32 bits, so it is only sign-extended
	assign m_axis_tdata = {press_s10, {{(RES_W-20){temp_s10[19]}}, temp_s10}};

endmodule

>>> src/ptc_checker.sv
// port-level checker for the compensation block and its bind
`include "pressure_temp_compensation_macros.svh"

module ptc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// a held result keeps its value
	`PTC_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

	// an empty output stage never back-pressures the input
	`PTC_ASSERT_IMP(a_in_ready_free, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

	// a stalled output freezes the whole pipe, so the input is not taken
	`PTC_ASSERT_IMP(a_in_stall, clk, arst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

	// compensated temperature stays within about 19 signed bits
	`PTC_ASSERT_IMP(a_temp_range, clk, arst_n, m_axis_tvalid, (m_axis_tdata[31:18] == 14'h0000) || (m_axis_tdata[31:18] == 14'h3FFF), "temperature out of range")

endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (.*);

>>> sim/pressure_temp_compensation_tb.sv
// testbench for the pressure/temperature compensation pipeline: directed corners, then random phases
module pressure_temp_compensation_tb;
	import ptc_pkg::*;

	localparam int     RESET_CYCLES = 11;
	localparam int     PIPE_LATENCY = 10;
	localparam int     STALL_LIMIT  = 2000;
	localparam int     IDLE_PCT     = 12;
	localparam int     PHASES       = 9;
	localparam int     PHASE_ITEMS  = 203;
	localparam longint RAW_MAX      = 64'sd16777215;
	localparam longint S32_MAX      = 64'sd2147483647;
	localparam longint S32_MIN      = -S32_MAX - 1;
	localparam longint LOW_T_DIV    = 64'sd8589934592;
	localparam longint HIGH_T_DIV   = 64'sd137438953472;

	// indexes past the last calibration word, writes to them must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd7;

	// calibration words of a typical part
	localparam ptc_cfg_t NOMINAL_CAL = '{
		sens_base:   16'd34982,
		off_base:    16'd36352,
		sens_tempco: 16'd20328,
		off_tempco:  16'd22354,
		ref_temp:    16'd26646,
		temp_coeff:  16'd26146
	};

	// ref_temp and temp_coeff chosen so that T = 2000 + dT/256 exactly
	localparam ptc_cfg_t ALIGNED_CAL = '{
		sens_base:   16'd40000,
		off_base:    16'd40000,
		sens_tempco: 16'd30000,
		off_tempco:  16'd30000,
		ref_temp:    16'd32768,
		temp_coeff:  16'd32768
	};

	typedef enum int {
		CAL_NOMINAL,
		CAL_SPREAD,
		CAL_CORNER
	} cal_style_t;

	typedef struct {
		logic [RES_W-1:0] temperature;
		logic [RES_W-1:0] pressure;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata = '0;   // raw_pressure[23:0], raw_temperature[47:24]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [63:0]          m_axis_tdata;        // temperature[31:0], pressure[63:32]
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CAL_W-1:0]     cfg_data = '0;

	// calibration as the block should hold it, updated on each config transfer
	ptc_cfg_t cal = '0;
	reading_t expected_readings[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	bit       gaps_on = 1'b1;

	pressure_temp_compensation u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [RES_W-1:0] saturate(input longint v);
		if (v > S32_MAX) begin
			return SAT_MAX;
		end
		if (v < S32_MIN) begin
			return SAT_MIN;
		end
		return v[RES_W-1:0];
	endfunction

	// first-order values, then the second-order branch picked by temperature
	function automatic reading_t compensate(input ptc_cfg_t c, input logic [RAW_W-1:0] d1_raw,
			input logic [RAW_W-1:0] d2_raw);
		longint d1, dt, sens, off, t, dev, cold, t_corr, off_corr, sens_corr, press;
		reading_t r;
		d1   = longint'(d1_raw);
		dt   = longint'(d2_raw) - longint'(c.ref_temp) * 256;
		sens = longint'(c.sens_base) * 32768 + (longint'(c.sens_tempco) * dt) / 256;
		off  = longint'(c.off_base) * 65536 + (longint'(c.off_tempco) * dt) / 128;
		t    = 2000 + (dt * longint'(c.temp_coeff)) / 8388608;
		dev  = t - 2000;
		if (t < 2000) begin
			t_corr    = (3 * dt * dt) / LOW_T_DIV;
			off_corr  = (3 * dev * dev) / 2;
			sens_corr = (5 * dev * dev) / 8;
			// very cold: extra terms on top of the low-temperature ones
			if (t < -1500) begin
				cold      = t + 1500;
				off_corr  = off_corr + 7 * cold * cold;
				sens_corr = sens_corr + 4 * cold * cold;
			end
		end else begin
			t_corr    = (2 * dt * dt) / HIGH_T_DIV;
			off_corr  = (dev * dev) / 16;
			sens_corr = 0;
		end
		press = ((d1 * (sens - sens_corr)) / 2097152 - (off - off_corr)) / 8192;
		r.temperature = saturate(t - t_corr);
		r.pressure    = saturate(press);
		return r;
	endfunction

	function automatic ptc_cfg_t pick_cal(input cal_style_t style);
		ptc_cfg_t c;
		logic [CAL_W-1:0] words [6];
		logic [CAL_W-1:0] nominal [6];
		nominal = '{NOMINAL_CAL.sens_base, NOMINAL_CAL.off_base, NOMINAL_CAL.sens_tempco,
			NOMINAL_CAL.off_tempco, NOMINAL_CAL.ref_temp, NOMINAL_CAL.temp_coeff};
		for (int i = 0; i < 6; i++) begin
			case (style)
				CAL_NOMINAL: words[i] = nominal[i] + CAL_W'($urandom_range(0, 4000)) - 16'd2000;
				CAL_SPREAD:  words[i] = CAL_W'($urandom_range(0, 65535));
				default:     words[i] = $urandom_range(0, 1) ? '1 : '0;
			endcase
		end
		c.sens_base   = words[0];
		c.off_base    = words[1];
		c.sens_tempco = words[2];
		c.off_tempco  = words[3];
		c.ref_temp    = words[4];
		c.temp_coeff  = words[5];
		return c;
	endfunction

	// keeps cfg_valid high, the caller lowers it after its last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SENS_BASE:   cal.sens_base   = val;
			REG_OFF_BASE:    cal.off_base    = val;
			REG_SENS_TEMPCO: cal.sens_tempco = val;
			REG_OFF_TEMPCO:  cal.off_tempco  = val;
			REG_REF_TEMP:    cal.ref_temp    = val;
			REG_TEMP_COEFF:  cal.temp_coeff  = val;
			default: ;
		endcase
	endtask

	// stop sending and wait for every outstanding reading
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_readings.size() != 0) @(posedge clk);
	endtask

	task automatic program_cal(input ptc_cfg_t c);
		drain();
		write_reg(REG_SENS_BASE, c.sens_base);
		write_reg(REG_OFF_BASE, c.off_base);
		write_reg(REG_SENS_TEMPCO, c.sens_tempco);
		write_reg(REG_OFF_TEMPCO, c.off_tempco);
		write_reg(REG_REF_TEMP, c.ref_temp);
		write_reg(REG_TEMP_COEFF, c.temp_coeff);
		cfg_valid <= 1'b0;
	endtask

	// tvalid stays high into the next call, it only drops for a gap or a drain
	task automatic send_pair(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
		while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {raw_t, raw_p};
		do @(posedge clk); while (!s_axis_tready);
		expected_readings.push_back(compensate(cal, raw_p, raw_t));
	endtask

	// raw temperature placed at an offset from the reference code, clamped to 24 bits
	task automatic send_dt(input logic [RAW_W-1:0] raw_p, input longint dt);
		longint d2;
		d2 = longint'(cal.ref_temp) * 256 + dt;
		if (d2 < 0) begin
			d2 = 0;
		end else if (d2 > RAW_MAX) begin
			d2 = RAW_MAX;
		end
		send_pair(raw_p, d2[RAW_W-1:0]);
	endtask

	task automatic send_random_pair();
		int sel, scale;
		logic [RAW_W-1:0] raw_p;
		longint dt;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 6) == 0) begin
			raw_p = $urandom_range(0, 1) ? '1 : '0;
		end else begin
			raw_p = RAW_W'($urandom());
		end
		if (sel < 60) begin
			// mostly near the reference so every temperature branch is hit
			scale = $urandom_range(4, 23);
			dt = longint'($urandom_range(0, (1 << scale) - 1));
			if ($urandom_range(0, 1)) begin
				dt = -dt;
			end
			send_dt(raw_p, dt);
		end else if (sel < 85) begin
			send_pair(raw_p, RAW_W'($urandom()));
		end else begin
			send_pair(raw_p, $urandom_range(0, 1) ? '1 : '0);
		end
	endtask

	// calibration still all zero after reset
	task automatic test_reset_calibration();
		send_pair('0, '0);
		send_pair('1, '1);
		send_pair('1, '0);
		send_pair('0, '1);
	endtask

	// both sides of the 20.00 C and -15.00 C thresholds, plus the raw extremes
	task automatic test_thresholds();
		program_cal(ALIGNED_CAL);
		send_dt('0, 0);
		send_dt('1, 0);
		send_dt(24'h5A5A5A, -255);
		send_dt(24'hA5A5A5, -256);
		send_dt(24'h800000, -896000);
		send_dt(24'h800000, -896256);
		send_pair('1, '0);
		send_pair('1, '1);
	endtask

	task automatic test_extreme_calibration();
		ptc_cfg_t c;
		program_cal('1);
		send_pair('0, '0);
		send_pair('1, '0);
		send_pair('0, '1);
		send_pair('1, '1);
		c = '{sens_base: '1, off_base: '0, sens_tempco: '1, off_tempco: '0,
			ref_temp: '0, temp_coeff: '1};
		program_cal(c);
		send_pair('0, '1);
		send_pair('1, '1);
		send_pair('1, '0);
		send_pair('0, '0);
	endtask

	// writes past the last register must leave the calibration alone
	task automatic test_unused_index();
		drain();
		write_reg(REG_UNUSED_A, '1);
		write_reg(REG_UNUSED_B, '0);
		cfg_valid <= 1'b0;
		send_pair('1, '1);
		send_pair(24'h123456, 24'h000100);
	endtask

	task automatic test_random_phases();
		int n;
		for (int phase = 0; phase < PHASES; phase++) begin
			program_cal(pick_cal(cal_style_t'(phase % 3)));
			// one whole phase runs with no gaps on either side
			gaps_on = (phase != 4);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off mid-phase until the pipe is empty
				if (phase == 2 && n == PHASE_ITEMS / 2) begin
					drain();
				end
				send_random_pair();
			end
		end
		gaps_on = 1'b1;
	endtask

	// receiver stalls at random while gaps are on
	always @(posedge clk) begin
		m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// each output transfer is matched against the oldest prediction
	always @(posedge clk) begin : reading_check
		reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_readings.size() == 0) begin
				mismatches++;
				$display("%0t: expected no reading, actual temperature %0d pressure %0d",
					$time, $signed(m_axis_tdata[31:0]), $signed(m_axis_tdata[63:32]));
			end else begin
				want = expected_readings.pop_front();
				if (m_axis_tdata[31:0] !== want.temperature) begin
					mismatches++;
					$display("%0t: temperature expected %0d, actual %0d", $time,
						$signed(want.temperature), $signed(m_axis_tdata[31:0]));
				end
				if (m_axis_tdata[63:32] !== want.pressure) begin
					mismatches++;
					$display("%0t: pressure expected %0d, actual %0d", $time,
						$signed(want.pressure), $signed(m_axis_tdata[63:32]));
				end
			end
		end
	end

	// ends the run when no transfer of any kind happens for too long
	always @(posedge clk) begin : watchdog
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_calibration();
		test_thresholds();
		test_extreme_calibration();
		test_unused_index();
		test_random_phases();
		drain();
		// late or extra readings would show up here
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (expected_readings.size() != 0) begin
			mismatches++;
			$display("%0t: %0d readings never arrived", $time, expected_readings.size());
		end
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/ptc_pkg.sv
src/ptc_cfg.sv
src/pressure_temp_compensation.sv
src/ptc_checker.sv
sim/pressure_temp_compensation_tb.sv
